/* hdl/assert_macros.svh */
// Assertion macros shared by the closure statistics RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* hdl/ipcs_pkg.sv */
// Types, constants and the arctangent table for the closure statistics unit.
// No dependencies.
package ipcs_pkg;
   localparam int CordicSteps = 30;
   localparam int DataBits    = 36;
   localparam int QueueDepth  = 4;
   localparam int QueueAw     = 2;

   typedef struct packed {
      logic signed [15:0] ab_real;
      logic signed [15:0] ab_imag;
      logic signed [15:0] bc_real;
      logic signed [15:0] bc_imag;
      logic signed [15:0] ca_real;
      logic signed [15:0] ca_imag;
      logic               last_pixel;
   } req_type;

   typedef struct packed {
      logic signed [16:0] closure_angle;
      logic               closure_valid;
      logic               stats_ready;
      logic [24:0]        evaluated_count;
      logic [24:0]        valid_count;
      logic [24:0]        invalid_count;
      logic [15:0]        max_abs_closure;
      logic [15:0]        rms_closure;
   } rsp_type;

   typedef struct packed {
      logic signed [16:0] closure;
      logic               ok;
      logic               last;
   } entry_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIV,
      B_SQRT
   } back_state_type;

   function automatic logic signed [DataBits-1:0] atan_step(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
         3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
         6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
         9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
        15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
        21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
        24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
        27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
         default: t = 32'h0;
      endcase
      return $signed({4'b0, t});
   endfunction
endpackage

/* hdl/insar_phase_closure_stats_unit.sv */
// Top level of the triplet phase closure statistics unit.
// Depends on ipcs_pkg, ipcs_front, ipcs_queue and ipcs_back.
//   port group | dir | payload            | handshake
//   req_       | in  | ipcs_pkg::req_type | req_valid / req_stall
//   rsp_       | out | ipcs_pkg::rsp_type | rsp_valid / rsp_stall
// One pixel a cycle enters a 31-stage CORDIC pipeline while req_stall is low.
// A last pixel with valid pixels holds the back part for a 57-step divide, a 29-step
// root and a step to form the beat; other pixels leave one a cycle unless stalled.
// Reset clears pipeline valids, queue, accumulators and the result beat valid.
// A stalled result backs up the 4-entry queue, then the pipeline and req_stall.
module insar_phase_closure_stats_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ipcs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ipcs_pkg::rsp_type rsp_data
);
   logic push, full, pop, empty;
   ipcs_pkg::entry_type push_data, pop_data;

   ipcs_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .push, .full, .push_data
   );

   ipcs_queue u_queue (
      .clock, .reset, .push, .push_data, .full, .pop, .empty, .pop_data
   );

   ipcs_back u_back (
      .clock, .reset, .empty, .pop_data, .pop, .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

/* hdl/ipcs_front.sv */
// Front part: pipelined CORDIC phase of three samples and wrapped closure.
// Depends on ipcs_pkg.
module ipcs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ipcs_pkg::req_type  req_data,
   output logic               push,
   input  logic               full,
   output ipcs_pkg::entry_type push_data
);
   localparam int N = ipcs_pkg::CordicSteps;
   localparam int W = ipcs_pkg::DataBits;

   logic signed [W-1:0] x_ff [0:N][0:2];
   logic signed [W-1:0] y_ff [0:N][0:2];
   logic signed [W-1:0] z_ff [0:N][0:2];
   logic signed [W-1:0] x_in [0:N][0:2];
   logic signed [W-1:0] y_in [0:N][0:2];
   logic signed [W-1:0] z_in [0:N][0:2];
   logic [N:0] v_ff, v_in, ok_ff, ok_in, last_ff, last_in;
   logic adv;
   logic signed [15:0] re [0:2];
   logic signed [15:0] im [0:2];
   logic signed [W-1:0] sum, q;
   logic [15:0] m;

   assign adv = !(v_ff[N] && full);
   assign req_stall = !adv;
   assign push = v_ff[N] && !full;

   assign re[0] = req_data.ab_real;
   assign im[0] = req_data.ab_imag;
   assign re[1] = req_data.bc_real;
   assign im[1] = req_data.bc_imag;
   assign re[2] = req_data.ca_real;
   assign im[2] = req_data.ca_imag;

   always_comb begin
      logic signed [W-1:0] xs, ys;
      v_in[0] = req_valid;
      last_in[0] = req_data.last_pixel;
      ok_in[0] = 1'b1;
      for (int j = 0; j < 3; j++) begin
         xs = {{(W-32){re[j][15]}}, re[j], 16'b0};
         ys = {{(W-32){im[j][15]}}, im[j], 16'b0};
         if (re[j] == 16'sd0 && im[j] == 16'sd0) ok_in[0] = 1'b0;
         if (xs < 0) begin
            if (ys >= 0) begin
               x_in[0][j] = ys;
               y_in[0][j] = -xs;
               z_in[0][j] = W'(32'sh40000000);
            end else begin
               x_in[0][j] = -ys;
               y_in[0][j] = xs;
               z_in[0][j] = -W'(32'sh40000000);
            end
         end else begin
            x_in[0][j] = xs;
            y_in[0][j] = ys;
            z_in[0][j] = '0;
         end
      end
      for (int k = 0; k < N; k++) begin
         v_in[k+1] = v_ff[k];
         ok_in[k+1] = ok_ff[k];
         last_in[k+1] = last_ff[k];
         for (int j = 0; j < 3; j++) begin
            if (y_ff[k][j] >= 0) begin
               x_in[k+1][j] = x_ff[k][j] + (y_ff[k][j] >>> k);
               y_in[k+1][j] = y_ff[k][j] - (x_ff[k][j] >>> k);
               z_in[k+1][j] = z_ff[k][j] + ipcs_pkg::atan_step(k);
            end else begin
               x_in[k+1][j] = x_ff[k][j] - (y_ff[k][j] >>> k);
               y_in[k+1][j] = y_ff[k][j] + (x_ff[k][j] >>> k);
               z_in[k+1][j] = z_ff[k][j] - ipcs_pkg::atan_step(k);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
      if (adv) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         ok_ff <= ok_in;
         last_ff <= last_in;
      end
   end

   always_comb begin
      sum = z_ff[N][0] + z_ff[N][1] + z_ff[N][2];
      q = (sum + W'(32'sd32768)) >>> 16;
      m = q[15:0];
      push_data.ok = ok_ff[N];
      push_data.last = last_ff[N];
      push_data.closure = ok_ff[N] ? $signed({m[15] & (|m[14:0]), m}) : '0;
   end
endmodule

/* hdl/ipcs_queue.sv */
// Short queue between front and back parts.
// Depends on ipcs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ipcs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ipcs_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output ipcs_pkg::entry_type pop_data
);
   localparam int D = ipcs_pkg::QueueDepth;
   localparam int A = ipcs_pkg::QueueAw;

   ipcs_pkg::entry_type mem_ff [0:D-1];
   logic [A-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [A:0]   cnt_ff, cnt_in;

   assign full = cnt_ff == (A+1)'(D);
   assign empty = cnt_ff == '0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (A+1)'(push) - (A+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

   `ASSERT_ALWAYS(a_no_overflow, clock, reset, !(push && full))
   `ASSERT_ALWAYS(a_no_underflow, clock, reset, !(pop && empty))
   `ASSERT_ALWAYS(a_count_range, clock, reset, cnt_ff <= (A+1)'(D))
endmodule

/* hdl/ipcs_back.sv */
// Back part: accumulators, divide and square root for the plane RMS, result beat.
// Depends on ipcs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ipcs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  ipcs_pkg::entry_type pop_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ipcs_pkg::rsp_type   rsp_data
);
   ipcs_pkg::back_state_type st_ff, st_in;
   logic [24:0] ev_ff, ev_in, va_ff, va_in, iv_ff, iv_in;
   logic [16:0] mx_ff, mx_in;
   logic [54:0] ss_ff, ss_in;
   logic        rv_ff, rv_in;
   ipcs_pkg::rsp_type rd_ff, rd_in;
   logic [56:0] dd_ff, dd_in;
   logic [25:0] rem_ff, rem_in;
   logic [24:0] dv_ff, dv_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [57:0] sv_ff, sv_in, res_ff, res_in, bit_ff, bit_in;
   logic [16:0] a;
   logic [33:0] sq;
   logic [25:0] r;
   logic [57:0] t;
   logic [29:0] rr;
   logic [16:0] rms;

   assign rsp_valid = rv_ff;
   assign rsp_data = rd_ff;

   always_comb begin
      st_in = st_ff;
      ev_in = ev_ff; va_in = va_ff; iv_in = iv_ff; mx_in = mx_ff; ss_in = ss_ff;
      rv_in = rv_ff && rsp_stall;
      rd_in = rd_ff;
      dd_in = dd_ff; rem_in = rem_ff; dv_in = dv_ff; cnt_in = cnt_ff;
      sv_in = sv_ff; res_in = res_ff; bit_in = bit_ff;
      pop = 1'b0;
      a = pop_data.closure[16] ? 17'(-pop_data.closure) : 17'(pop_data.closure);
      sq = a * a;
      r = {rem_ff[24:0], dd_ff[56]};
      t = res_ff + bit_ff;
      rr = 30'(res_ff) + 30'd1;
      rms = (rr[29:1] > 29'd32768) ? 17'd32768 : rr[17:1];
      case (st_ff)
         ipcs_pkg::B_IDLE: begin
            if (!empty && (!rv_ff || !rsp_stall)) begin
               pop = 1'b1;
               if (!ev_ff[24]) begin
                  ev_in = ev_ff + 25'd1;
                  if (pop_data.ok) begin
                     va_in = va_ff + 25'd1;
                     if (a > mx_ff) mx_in = a;
                     ss_in = ss_ff + 55'(sq);
                  end else begin
                     iv_in = iv_ff + 25'd1;
                  end
               end
               rd_in.closure_angle = pop_data.closure;
               rd_in.closure_valid = pop_data.ok;
               rd_in.stats_ready = pop_data.last;
               rd_in.evaluated_count = ev_in;
               rd_in.valid_count = va_in;
               rd_in.invalid_count = iv_in;
               rd_in.max_abs_closure = mx_in[15:0];
               rd_in.rms_closure = '0;
               rv_in = 1'b1;
               if (pop_data.last) begin
                  if (va_in != '0) begin
                     rv_in = 1'b0;
                     dd_in = {ss_in, 2'b00};
                     dv_in = va_in;
                     rem_in = '0;
                     cnt_in = 6'd57;
                     st_in = ipcs_pkg::B_DIV;
                  end
                  ev_in = '0; va_in = '0; iv_in = '0; mx_in = '0; ss_in = '0;
               end
            end
         end
         ipcs_pkg::B_DIV: begin
            if (r >= {1'b0, dv_ff}) begin
               rem_in = r - {1'b0, dv_ff};
               dd_in = {dd_ff[55:0], 1'b1};
            end else begin
               rem_in = r;
               dd_in = {dd_ff[55:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               sv_in = {1'b0, dd_in};
               res_in = '0;
               bit_in = 58'd1 << 56;
               st_in = ipcs_pkg::B_SQRT;
            end
         end
         ipcs_pkg::B_SQRT: begin
            if (bit_ff != '0) begin
               if (sv_ff >= t) begin
                  sv_in = sv_ff - t;
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end else begin
               rd_in.rms_closure = rms[15:0];
               rv_in = 1'b1;
               st_in = ipcs_pkg::B_IDLE;
            end
         end
         default: st_in = ipcs_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ipcs_pkg::B_IDLE;
         ev_ff <= '0; va_ff <= '0; iv_ff <= '0; mx_ff <= '0; ss_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ev_ff <= ev_in; va_ff <= va_in; iv_ff <= iv_in; mx_ff <= mx_in; ss_ff <= ss_in;
         rv_ff <= rv_in;
      end
      rd_ff <= rd_in;
      dd_ff <= dd_in; rem_ff <= rem_in; dv_ff <= dv_in; cnt_ff <= cnt_in;
      sv_ff <= sv_in; res_ff <= res_in; bit_ff <= bit_in;
   end

   `ASSERT_IMPLIES(a_busy_no_beat, clock, reset, st_ff != ipcs_pkg::B_IDLE, !rv_ff)
   `ASSERT_ALWAYS(a_counts_sum, clock, reset, va_ff + iv_ff == ev_ff)
   `ASSERT_ALWAYS(a_max_range, clock, reset, mx_ff <= 17'd32768)
endmodule

/* bench/testbench.sv */
// Self-checking bench for insar_phase_closure_stats_unit: CORDIC closure and plane statistics.
// Depends on ipcs_pkg and the unit RTL; predicts each result beat and compares in order.
`timescale 1ns / 1ps
module testbench;
   localparam int IdleLimit = 20000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   ipcs_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   ipcs_pkg::rsp_type rsp_data;

   insar_phase_closure_stats_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   ipcs_pkg::rsp_type closure_expected[$];
   int      errors = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      quiet_cycles = 0;

   longint  n_eval, n_valid, n_invalid, peak_abs, sq_sum;

   const longint AtanTab[30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
      64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

   function automatic longint phase_of(input logic signed [15:0] re, logic signed [15:0] im);
      longint x, y, z, t, dx, dy;
      x = longint'(re) <<< 16;
      y = longint'(im) <<< 16;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 64'sd1 <<< 30;
         end else begin
            x = -y; y = t; z = -(64'sd1 <<< 30);
         end
      end
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += AtanTab[i];
         end else begin
            x -= dx; y += dy; z -= AtanTab[i];
         end
      end
      return z;
   endfunction

   function automatic longint int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic ipcs_pkg::rsp_type predict_closure(input ipcs_pkg::req_type p);
      ipcs_pkg::rsp_type r;
      bit      ok;
      longint  q, m, cl, a, rms;
      ok = !(p.ab_real == 0 && p.ab_imag == 0) && !(p.bc_real == 0 && p.bc_imag == 0)
         && !(p.ca_real == 0 && p.ca_imag == 0);
      cl = 0;
      if (ok) begin
         q = (phase_of(p.ab_real, p.ab_imag) + phase_of(p.bc_real, p.bc_imag)
            + phase_of(p.ca_real, p.ca_imag) + 32768) >>> 16;
         m = q & 64'hFFFF;
         cl = (m > 32768) ? m - 65536 : m;
      end
      if (n_eval < 16777216) begin
         n_eval++;
         if (ok) begin
            a = cl < 0 ? -cl : cl;
            n_valid++;
            if (a > peak_abs) peak_abs = a;
            sq_sum += a * a;
         end else n_invalid++;
      end
      rms = 0;
      if (p.last_pixel && n_valid > 0) begin
         rms = (int_sqrt((sq_sum * 4) / n_valid) + 1) >> 1;
         if (rms > 32768) rms = 32768;
      end
      r.closure_angle   = cl[16:0];
      r.closure_valid   = ok;
      r.stats_ready     = p.last_pixel;
      r.evaluated_count = n_eval[24:0];
      r.valid_count     = n_valid[24:0];
      r.invalid_count   = n_invalid[24:0];
      r.max_abs_closure = peak_abs[15:0];
      r.rms_closure     = rms[15:0];
      if (p.last_pixel) begin
         n_eval = 0; n_valid = 0; n_invalid = 0; peak_abs = 0; sq_sum = 0;
      end
      return r;
   endfunction

   task automatic send_pixel(input ipcs_pkg::req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      closure_expected.push_back(predict_closure(p));
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      ipcs_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (closure_expected.size() == 0) begin
            $display("%t unexpected beat: expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            e = closure_expected.pop_front();
            if (e.closure_angle !== rsp_data.closure_angle)
               $display("%t closure_angle exp %0d act %0d", $time,
                  e.closure_angle, rsp_data.closure_angle);
            if (e.closure_valid !== rsp_data.closure_valid)
               $display("%t closure_valid exp %0d act %0d", $time,
                  e.closure_valid, rsp_data.closure_valid);
            if (e.stats_ready !== rsp_data.stats_ready)
               $display("%t stats_ready exp %0d act %0d", $time,
                  e.stats_ready, rsp_data.stats_ready);
            if (e.evaluated_count !== rsp_data.evaluated_count)
               $display("%t evaluated_count exp %0d act %0d", $time,
                  e.evaluated_count, rsp_data.evaluated_count);
            if (e.valid_count !== rsp_data.valid_count)
               $display("%t valid_count exp %0d act %0d", $time,
                  e.valid_count, rsp_data.valid_count);
            if (e.invalid_count !== rsp_data.invalid_count)
               $display("%t invalid_count exp %0d act %0d", $time,
                  e.invalid_count, rsp_data.invalid_count);
            if (e.max_abs_closure !== rsp_data.max_abs_closure)
               $display("%t max_abs_closure exp %0d act %0d", $time,
                  e.max_abs_closure, rsp_data.max_abs_closure);
            if (e.rms_closure !== rsp_data.rms_closure)
               $display("%t rms_closure exp %0d act %0d", $time,
                  e.rms_closure, rsp_data.rms_closure);
            if (e !== rsp_data) errors++;
         end
      end
   end

   // watchdog on beats moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'(signed'($urandom_range(8) - 4));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic ipcs_pkg::req_type rand_pixel(input bit last, input bit allow_zero);
      ipcs_pkg::req_type p;
      p.ab_real = rand_comp(); p.ab_imag = rand_comp();
      p.bc_real = rand_comp(); p.bc_imag = rand_comp();
      p.ca_real = rand_comp(); p.ca_imag = rand_comp();
      if (allow_zero && $urandom_range(9) == 0) begin
         case ($urandom_range(2))
            0: {p.ab_real, p.ab_imag} = '0;
            1: {p.bc_real, p.bc_imag} = '0;
            default: {p.ca_real, p.ca_imag} = '0;
         endcase
      end
      p.last_pixel = last;
      return p;
   endfunction

   function automatic ipcs_pkg::req_type mk(input int ar, ai, br, bi, cr, ci, bit last);
      ipcs_pkg::req_type p;
      p.ab_real = ar[15:0]; p.ab_imag = ai[15:0];
      p.bc_real = br[15:0]; p.bc_imag = bi[15:0];
      p.ca_real = cr[15:0]; p.ca_imag = ci[15:0];
      p.last_pixel = last;
      return p;
   endfunction

   task automatic test_extremes();
      send_pixel(mk(32767, 0, 32767, 0, 32767, 0, 0));
      send_pixel(mk(-32768, 0, -32768, 0, 32767, 0, 0));
      send_pixel(mk(-32768, -1, -32768, -1, -32768, -1, 0));
      send_pixel(mk(0, 32767, 0, 32767, 0, -32768, 0));
      send_pixel(mk(-32768, -32768, 32767, 32767, -1, 1, 0));
      send_pixel(mk(-1, 0, -1, 0, -1, 0, 0));
      send_pixel(mk(-1, 0, 0, 1, 1, -1, 1));
   endtask

   task automatic test_invalid_pixels();
      send_pixel(mk(0, 0, 5, 5, 5, 5, 0));
      send_pixel(mk(5, 5, 0, 0, 5, 5, 0));
      send_pixel(mk(5, 5, 5, 5, 0, 0, 0));
      send_pixel(mk(1, 0, 0, 0, 0, 0, 0));
      send_pixel(mk(0, 0, 0, 0, 0, 0, 1));
      send_pixel(mk(0, 0, 1, 2, 3, 4, 1));
   endtask

   task automatic test_short_planes();
      send_pixel(mk(-32768, 1, -32768, 1, -32768, 1, 1));
      send_pixel(mk(100, -200, -300, 400, 500, 600, 1));
      send_pixel(mk(7, 7, 7, 7, 7, 7, 0));
      send_pixel(mk(0, -1, 0, -1, 0, -1, 1));
   endtask

   task automatic test_random_planes(input int n_items, input int idle, input int stall);
      int sent, len;
      send_idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(150, 40) : $urandom_range(12, 1);
         for (int i = 1; i <= len; i++) send_pixel(rand_pixel(i == len, 1));
         sent += len;
      end
   endtask

   initial begin
      n_eval = 0; n_valid = 0; n_invalid = 0; peak_abs = 0; sq_sum = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_extremes();
      test_invalid_pixels();
      test_short_planes();
      test_random_planes(340, 0, 0);
      test_random_planes(340, 62, 0);
      test_random_planes(340, 0, 62);
      test_random_planes(330, 38, 38);
      req_valid <= 0;
      while (closure_expected.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

/* sim.f */
+incdir+hdl
hdl/ipcs_pkg.sv
hdl/ipcs_front.sv
hdl/ipcs_queue.sv
hdl/ipcs_back.sv
hdl/insar_phase_closure_stats_unit.sv
bench/testbench.sv
